// File: rtl/core/tpja_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpja_pkg
// Constants and types shared by the joint angle pipeline and its channels.
// ---------------------------------------------------------------------------
package tpja_pkg;

	localparam int COORD_BITS   = 15;
	localparam int CORDIC_STEPS = 20;
	localparam int ANGLE_BITS   = 8;

	localparam int FRAC_BITS = 20;
	localparam int NORM_BITS = 29;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int MAG_W  = PROD_W + 2;
	localparam int EXTRA  = (MAG_W > NORM_BITS) ? MAG_W - NORM_BITS : 0;
	localparam int SH_W   = (EXTRA > 0) ? $clog2(EXTRA + 1) : 1;
	localparam int SQ_W   = 2 * NORM_BITS + 2;
	localparam int RT_STEPS = NORM_BITS + 1;
	localparam int CW     = RT_STEPS + 4;
	localparam int ZW     = 32;
	localparam int STEPS  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	// atan(2^-i) in units of 2^-20 degree
	localparam int ATAN_TAB [32] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7,
		4, 2, 1, 0, 0, 0, 0, 0
	};

	localparam int GUARD    = ATAN_TAB[STEPS - 1] + STEPS;
	localparam int BASE_90  = 90 * (1 << FRAC_BITS);
	localparam int DEG_MAX  = 180;

	// side information that rides along the square root stages
	typedef struct packed {
		logic                 degen;
		logic                 dneg;
		logic                 dzero;
		logic [NORM_BITS-1:0] dm;
	} rt_info_t;

	// side information that rides along the rotation stages
	typedef struct packed {
		logic                  degen;
		logic                  spec;
		logic [ANGLE_BITS-1:0] spec_deg;
		logic                  dneg;
	} cr_info_t;

endpackage

// File: rtl/core/tpja_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpja channels
// Valid/ready channels for the point triple and the angle result.
// ---------------------------------------------------------------------------
interface tpja_req_if;
	import tpja_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] first_z;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic signed [COORD_BITS-1:0] vertex_z;
	logic signed [COORD_BITS-1:0] third_x;
	logic signed [COORD_BITS-1:0] third_y;
	logic signed [COORD_BITS-1:0] third_z;

	modport source (output valid, first_x, first_y, first_z, vertex_x, vertex_y, vertex_z,
		third_x, third_y, third_z, input ready);
	modport sink (input valid, first_x, first_y, first_z, vertex_x, vertex_y, vertex_z,
		third_x, third_y, third_z, output ready);
endinterface

interface tpja_rsp_if;
	import tpja_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle_deg;
	logic                  degenerate;

	modport source (output valid, angle_deg, degenerate, input ready);
	modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

// File: rtl/core/three_point_joint_angle.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_point_joint_angle
// Angle at the middle of three 3-D points, whole degrees 0..180, from exact
// integer dot/cross products, a bit-per-stage square root and CORDIC atan2.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken.
// Reset clears all valid bits; payload registers are not reset.
module three_point_joint_angle (
	input  logic       clk,
	input  logic       arst_n,
	tpja_req_if.sink   req,
	tpja_rsp_if.source rsp
);
	import tpja_pkg::*;

	logic adv;
	logic vld_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic degen_q;

	assign adv       = !vld_q || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = vld_q;
	assign rsp.angle_deg  = angle_q;
	assign rsp.degenerate = degen_q;

	// ---------------- stage 1: difference vectors
	logic v_s1;
	logic signed [DIFF_W-1:0] u_s1 [3];
	logic signed [DIFF_W-1:0] w_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1[0] <= DIFF_W'(req.first_x) - DIFF_W'(req.vertex_x);
			u_s1[1] <= DIFF_W'(req.first_y) - DIFF_W'(req.vertex_y);
			u_s1[2] <= DIFF_W'(req.first_z) - DIFF_W'(req.vertex_z);
			w_s1[0] <= DIFF_W'(req.third_x) - DIFF_W'(req.vertex_x);
			w_s1[1] <= DIFF_W'(req.third_y) - DIFF_W'(req.vertex_y);
			w_s1[2] <= DIFF_W'(req.third_z) - DIFF_W'(req.vertex_z);
		end
	end

	// ---------------- stage 2: nine products
	logic v_s2, degen_s2;
	logic signed [PROD_W-1:0] p_s2 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s2 <= (u_s1[0] == '0 && u_s1[1] == '0 && u_s1[2] == '0) ||
				(w_s1[0] == '0 && w_s1[1] == '0 && w_s1[2] == '0);
			p_s2[0] <= PROD_W'(u_s1[0] * w_s1[0]);
			p_s2[1] <= PROD_W'(u_s1[1] * w_s1[1]);
			p_s2[2] <= PROD_W'(u_s1[2] * w_s1[2]);
			p_s2[3] <= PROD_W'(u_s1[1] * w_s1[2]);
			p_s2[4] <= PROD_W'(u_s1[2] * w_s1[1]);
			p_s2[5] <= PROD_W'(u_s1[2] * w_s1[0]);
			p_s2[6] <= PROD_W'(u_s1[0] * w_s1[2]);
			p_s2[7] <= PROD_W'(u_s1[0] * w_s1[1]);
			p_s2[8] <= PROD_W'(u_s1[1] * w_s1[0]);
		end
	end

	// ---------------- stage 3: dot, cross, magnitudes
	logic signed [MAG_W-1:0] dot_c;
	logic signed [MAG_W-1:0] cr_c [3];
	logic v_s3, degen_s3, dneg_s3, dzero_s3;
	logic [MAG_W-1:0] c_s3 [3];
	logic [MAG_W-1:0] dm_s3;

	always_comb begin
		dot_c = MAG_W'(p_s2[0]) + MAG_W'(p_s2[1]) + MAG_W'(p_s2[2]);
		cr_c[0] = MAG_W'(p_s2[3]) - MAG_W'(p_s2[4]);
		cr_c[1] = MAG_W'(p_s2[5]) - MAG_W'(p_s2[6]);
		cr_c[2] = MAG_W'(p_s2[7]) - MAG_W'(p_s2[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s3 <= degen_s2;
			dneg_s3  <= dot_c[MAG_W-1];
			dzero_s3 <= (dot_c == '0);
			dm_s3    <= dot_c[MAG_W-1] ? MAG_W'(-dot_c) : MAG_W'(dot_c);
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= cr_c[i][MAG_W-1] ? MAG_W'(-cr_c[i]) : MAG_W'(cr_c[i]);
			end
		end
	end

	// ---------------- stage 4: common right shift below 2^NORM_BITS
	logic [MAG_W-1:0] or_c;
	logic [SH_W-1:0]  sh_c;
	logic v_s4;
	rt_info_t info_s4;
	logic [NORM_BITS-1:0] cn_s4 [3];

	always_comb begin
		or_c = c_s3[0] | c_s3[1] | c_s3[2] | dm_s3;
		sh_c = '0;
		for (int k = NORM_BITS; k < MAG_W; k++) begin
			if (or_c[k]) begin
				sh_c = SH_W'(k - NORM_BITS + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [MAG_W+NORM_BITS-1:0] wd;
		if (adv) begin
			info_s4.degen <= degen_s3;
			info_s4.dneg  <= dneg_s3;
			info_s4.dzero <= dzero_s3;
			wd = {{NORM_BITS{1'b0}}, dm_s3} >> sh_c;
			info_s4.dm <= wd[NORM_BITS-1:0];
			for (int i = 0; i < 3; i++) begin
				wd = {{NORM_BITS{1'b0}}, c_s3[i]} >> sh_c;
				cn_s4[i] <= wd[NORM_BITS-1:0];
			end
		end
	end

	// ---------------- stage 5: squares
	logic v_s5;
	rt_info_t info_s5;
	logic [2*NORM_BITS-1:0] sq_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s5 <= info_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= cn_s4[i] * cn_s4[i];
			end
		end
	end

	// ---------------- stage 6 and square root stages: one result bit each
	logic                  rt_v_s    [RT_STEPS+1];
	rt_info_t              rt_info_s [RT_STEPS+1];
	logic [SQ_W-1:0]       rt_n_s    [RT_STEPS+1];
	logic [SQ_W-1:0]       rt_res_s  [RT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (adv) begin
			rt_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_info_s[0] <= info_s5;
			rt_n_s[0]    <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
			rt_res_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (RT_STEPS - 1 - k));
		logic [SQ_W:0] t_c;

		assign t_c = {1'b0, rt_res_s[k]} + {1'b0, BITV};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_info_s[k+1] <= rt_info_s[k];
				if ({1'b0, rt_n_s[k]} >= t_c) begin
					rt_n_s[k+1]   <= SQ_W'({1'b0, rt_n_s[k]} - t_c);
					rt_res_s[k+1] <= (rt_res_s[k] >> 1) + BITV;
				end else begin
					rt_n_s[k+1]   <= rt_n_s[k];
					rt_res_s[k+1] <= rt_res_s[k] >> 1;
				end
			end
		end
	end

	// ---------------- rotation setup
	logic [RT_STEPS-1:0] m_c;
	rt_info_t            ri_c;
	logic                  cr_v_s    [STEPS+1];
	cr_info_t              cr_info_s [STEPS+1];
	logic signed [CW-1:0]  cr_x_s    [STEPS+1];
	logic signed [CW-1:0]  cr_y_s    [STEPS+1];
	logic signed [ZW-1:0]  cr_z_s    [STEPS+1];

	assign m_c  = rt_res_s[RT_STEPS][RT_STEPS-1:0];
	assign ri_c = rt_info_s[RT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_v_s[0] <= 1'b0;
		end else if (adv) begin
			cr_v_s[0] <= rt_v_s[RT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_info_s[0].degen <= ri_c.degen;
			cr_info_s[0].dneg  <= ri_c.dneg;
			if (ri_c.dzero) begin
				cr_info_s[0].spec     <= 1'b1;
				cr_info_s[0].spec_deg <= ANGLE_BITS'(90);
			end else if (m_c == '0) begin
				cr_info_s[0].spec     <= 1'b1;
				cr_info_s[0].spec_deg <= ri_c.dneg ? ANGLE_BITS'(DEG_MAX) : '0;
			end else begin
				cr_info_s[0].spec     <= 1'b0;
				cr_info_s[0].spec_deg <= '0;
			end
			// obtuse: rotate (m, |d|) and add 90 degrees at the end
			if (ri_c.dneg) begin
				cr_x_s[0] <= CW'(m_c);
				cr_y_s[0] <= CW'(ri_c.dm);
			end else begin
				cr_x_s[0] <= CW'(ri_c.dm);
				cr_y_s[0] <= CW'(m_c);
			end
			cr_z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_cr
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[k]);
		logic signed [CW-1:0] xs_c, ys_c;

		assign xs_c = cr_x_s[k] >>> k;
		assign ys_c = cr_y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				cr_v_s[k+1] <= cr_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cr_info_s[k+1] <= cr_info_s[k];
				if (!cr_y_s[k][CW-1]) begin
					cr_x_s[k+1] <= cr_x_s[k] + ys_c;
					cr_y_s[k+1] <= cr_y_s[k] - xs_c;
					cr_z_s[k+1] <= cr_z_s[k] + ANG;
				end else begin
					cr_x_s[k+1] <= cr_x_s[k] - ys_c;
					cr_y_s[k+1] <= cr_y_s[k] + xs_c;
					cr_z_s[k+1] <= cr_z_s[k] - ANG;
				end
			end
		end
	end

	// ---------------- final: guard, truncate, clamp
	logic signed [ZW-1:0] total_c;
	logic [ZW-FRAC_BITS-1:0] whole_c;
	logic [ANGLE_BITS-1:0] deg_c;
	cr_info_t fi_c;

	assign fi_c = cr_info_s[STEPS];

	always_comb begin
		total_c = cr_z_s[STEPS] + ZW'(GUARD) + (fi_c.dneg ? ZW'(BASE_90) : ZW'(0));
		whole_c = total_c[ZW-1] ? '0 : total_c[ZW-1:FRAC_BITS];
		if (fi_c.degen) begin
			deg_c = '0;
		end else if (fi_c.spec) begin
			deg_c = fi_c.spec_deg;
		end else if (whole_c > (ZW-FRAC_BITS)'(DEG_MAX)) begin
			deg_c = ANGLE_BITS'(DEG_MAX);
		end else begin
			deg_c = whole_c[ANGLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= cr_v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q <= deg_c;
			degen_q <= fi_c.degen;
		end
	end

endmodule

// File: tb/tb_three_point_joint_angle.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_three_point_joint_angle
// Drives point triples into the joint angle pipeline with random gaps on
// both channels and checks each angle against an integer CORDIC predictor.
// ---------------------------------------------------------------------------
module tb_three_point_joint_angle;
	import tpja_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t pt [9];
		logic   known;
		logic [ANGLE_BITS-1:0] deg;
		logic   degen;
	} stim_row_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] deg;
		logic                  degen;
	} angle_res_t;

	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN      = 80;
	localparam coord_t CMAX   = (1 <<< (COORD_BITS - 1)) - 1;
	localparam coord_t CMIN   = -(1 <<< (COORD_BITS - 1));

	logic clk;
	logic arst_n;
	tpja_req_if req ();
	tpja_rsp_if rsp ();

	three_point_joint_angle u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	angle_res_t angle_q [$];
	int         mismatches;
	int         cycles;
	stim_row_t  rows [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_sh(longint v, int s);
		if (v >= 0) return v >>> s;
		return ~((~v) >>> s);
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint res, bit_w;
		res = 0;
		bit_w = 64'sd1 <<< 62;
		while (bit_w > n) bit_w = bit_w >>> 2;
		while (bit_w != 0) begin
			if (n >= res + bit_w) begin
				n = n - (res + bit_w);
				res = (res >>> 1) + bit_w;
			end else begin
				res = res >>> 1;
			end
			bit_w = bit_w >>> 2;
		end
		return res;
	endfunction

	function automatic angle_res_t joint_angle(coord_t pt [9]);
		longint ux, uy, uz, vx, vy, vz, dot, cx, cy, cz, dm, m;
		longint x, y, z, xs, ys, base, total;
		logic dneg;
		angle_res_t r;
		ux = pt[0] - pt[3]; uy = pt[1] - pt[4]; uz = pt[2] - pt[5];
		vx = pt[6] - pt[3]; vy = pt[7] - pt[4]; vz = pt[8] - pt[5];
		r.degen = 1'b0;
		if ((ux == 0 && uy == 0 && uz == 0) || (vx == 0 && vy == 0 && vz == 0)) begin
			r.deg = 0;
			r.degen = 1'b1;
			return r;
		end
		dot = ux * vx + uy * vy + uz * vz;
		cx = magnitude(uy * vz - uz * vy);
		cy = magnitude(uz * vx - ux * vz);
		cz = magnitude(ux * vy - uy * vx);
		dm = magnitude(dot);
		dneg = dot < 0;
		while (cx >= (64'sd1 <<< NORM_BITS) || cy >= (64'sd1 <<< NORM_BITS) ||
				cz >= (64'sd1 <<< NORM_BITS) || dm >= (64'sd1 <<< NORM_BITS)) begin
			cx = cx >>> 1; cy = cy >>> 1; cz = cz >>> 1; dm = dm >>> 1;
		end
		m = int_sqrt(cx * cx + cy * cy + cz * cz);
		if (dot == 0) begin
			r.deg = 90;
		end else if (m == 0) begin
			r.deg = dneg ? 180 : 0;
		end else begin
			// obtuse side rotates (m, |d|) and adds a quarter turn
			if (dneg) begin
				x = m; y = dm; base = 90 * (64'sd1 <<< FRAC_BITS);
			end else begin
				x = dm; y = m; base = 0;
			end
			z = 0;
			for (int i = 0; i < STEPS; i++) begin
				xs = floor_sh(x, i);
				ys = floor_sh(y, i);
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
				end else begin
					x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
				end
			end
			total = base + z + ATAN_TAB[(STEPS - 1) & 31] + STEPS;
			if (total < 0) total = 0;
			total = total >>> FRAC_BITS;
			r.deg = (total > DEG_MAX) ? DEG_MAX : total[ANGLE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 40)) - 20;
			default: return ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3)
				: CMIN + $urandom_range(0, 3);
		endcase
	endfunction

	task automatic add_row(coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2,
			logic known, logic [ANGLE_BITS-1:0] deg, logic degen);
		stim_row_t r;
		r.pt = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
		r.known = known;
		r.deg = deg;
		r.degen = degen;
		rows.push_back(r);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	// with valid still high, so back-to-back items need not drop valid between them
	task automatic send(coord_t pt [9]);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid    <= 1'b1;
		req.first_x  <= pt[0]; req.first_y  <= pt[1]; req.first_z  <= pt[2];
		req.vertex_x <= pt[3]; req.vertex_y <= pt[4]; req.vertex_z <= pt[5];
		req.third_x  <= pt[6]; req.third_y  <= pt[7]; req.third_z  <= pt[8];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		angle_q.push_back(joint_angle(pt));
		@(negedge clk);
	endtask

	// sink side: random stall before each transfer is allowed
	initial begin
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		angle_res_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (angle_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result angle=%0d degen=%0b",
						rsp.angle_deg, rsp.degenerate);
			end else begin
				exp_r = angle_q.pop_front();
				if (rsp.angle_deg !== exp_r.deg || rsp.degenerate !== exp_r.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp angle=%0d degen=%0b, got angle=%0d degen=%0b",
							exp_r.deg, exp_r.degen, rsp.angle_deg, rsp.degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("three_point_joint_angle regression: fail");
			$finish;
		end
	end

	initial begin
		coord_t pt [9];
		angle_res_t chk;
		int mode;
		mismatches = 0;
		cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.first_x = '0; req.first_y = '0; req.first_z = '0;
		req.vertex_x = '0; req.vertex_y = '0; req.vertex_z = '0;
		req.third_x = '0; req.third_y = '0; req.third_z = '0;

		// directed table: zero vectors, perpendicular, collinear, extremes
		add_row(0, 0, 0, 0, 0, 0, 5, 5, 5, 1, 0, 1);
		add_row(7, 7, 7, 1, 2, 3, 1, 2, 3, 1, 0, 1);
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1);
		add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, 0, 1);
		add_row(10, 0, 0, 0, 0, 0, 0, 10, 0, 1, 90, 0);
		add_row(CMAX, 0, 0, 0, 0, 0, 0, 0, CMIN, 1, 90, 0);
		add_row(5, 0, 0, 0, 0, 0, 9, 0, 0, 1, 0, 0);
		add_row(5, 0, 0, 0, 0, 0, -9, 0, 0, 1, 180, 0);
		add_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0, 0);
		add_row(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0);
		add_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, 0, 0, 0);
		add_row(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 0, 0, 0);
		add_row(1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 0, 0, -1, 1, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 0, 0, 1000, 1, 0, 0, 0, 0);
		add_row(-1000, 1, 0, 0, 0, 0, 1000, 0, 0, 0, 0, 0);
		add_row(1, 2, 3, 4, 5, 6, 7, 8, 10, 0, 0, 0);
		add_row(CMAX, 0, 0, CMIN, 0, 0, CMIN, 1, 0, 0, 0, 0);
		add_row(-1, -1, -1, 0, 0, 0, 1, -1, 1, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			pt = rows[i].pt;
			if (rows[i].known) begin
				chk = joint_angle(pt);
				if (chk.deg !== rows[i].deg || chk.degen !== rows[i].degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("predictor row %0d: table angle=%0d degen=%0b, calc %0d/%0b",
							i, rows[i].deg, rows[i].degen, chk.deg, chk.degen);
				end
			end
			send(pt);
		end

		// hold off until the pipeline has fully drained
		req.valid <= 1'b0;
		while (angle_q.size() != 0) @(negedge clk);

		for (int n = 0; n < 600; n++) begin
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++)
				pt[k] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
			// occasional degenerate or collinear triples
			case ($urandom_range(0, 19))
				0: begin pt[0] = pt[3]; pt[1] = pt[4]; pt[2] = pt[5]; end
				1: begin pt[6] = pt[3]; pt[7] = pt[4]; pt[8] = pt[5]; end
				2: for (int k = 0; k < 3; k++) pt[6+k] = pt[3+k] - (pt[k] - pt[3+k]) / 2;
				default: ;
			endcase
			send(pt);
		end
		req.valid <= 1'b0;

		while (angle_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && angle_q.size() == 0)
			$display("three_point_joint_angle regression: pass");
		else
			$display("three_point_joint_angle regression: fail");
		$finish;
	end

endmodule

// File: three_point_joint_angle.f
rtl/core/tpja_pkg.sv
rtl/core/tpja_if.sv
rtl/core/three_point_joint_angle.sv
tb/tb_three_point_joint_angle.sv
